>>> rtl/core/pwn_pkg.sv
package pwn_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int COORD_W      = 24;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int SUM_W        = $clog2(MAX_VERTICES) + 2;
    localparam int WIND_W       = SUM_W - 1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [WIND_W-1:0]  wind_t;

    localparam sum_t SUM_MAX = sum_t'(MAX_VERTICES);
    localparam sum_t SUM_MIN = sum_t'(-MAX_VERTICES);
    localparam wind_t WIND_MAX = wind_t'(MAX_VERTICES / 2);
    localparam wind_t WIND_MIN = wind_t'(-(MAX_VERTICES / 2));

    function automatic diff_t coord_diff(input coord_t p, input coord_t a);
        return diff_t'(p) - diff_t'(a);
    endfunction

    // add one crossing sign and clamp to the vertex bound
    function automatic sum_t sat_step(input sum_t s, input logic up, input logic dn);
        sum_t t;
        t = s;
        if (up) begin
            t = s + sum_t'(1);
        end else if (dn) begin
            t = s - sum_t'(1);
        end
        if (t > SUM_MAX) begin
            t = SUM_MAX;
        end else if (t < SUM_MIN) begin
            t = SUM_MIN;
        end
        return t;
    endfunction

    // half the sum, truncated toward zero
    function automatic wind_t half_sum(input sum_t n);
        sum_t h;
        h = n + {{(SUM_W-1){1'b0}}, n[SUM_W-1]};
        return wind_t'(h[SUM_W-1:1]);
    endfunction

endpackage

>>> rtl/core/polygon_winding_number_core.sv
// channel | direction | beat
// s_      | in        | query_x, query_y, vertex_x, vertex_y, last_vertex
// m_      | out       | winding, one beat per vertex marked last
//
// one vertex per cycle while s_ready is high; each result is registered
// stages: coordinate differences, four 25x25 products, compare and sum update
// vertices that are not last keep flowing while a result waits on m_ready
// aresetn is synchronous, active low, and clears all valid flags and the sum
module polygon_winding_number_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  pwn_pkg::coord_t        s_query_x,
    input  pwn_pkg::coord_t        s_query_y,
    input  pwn_pkg::coord_t        s_vertex_x,
    input  pwn_pkg::coord_t        s_vertex_y,
    input  logic                   s_last_vertex,
    output logic                   m_valid,
    input  logic                   m_ready,
    output pwn_pkg::wind_t         m_winding
);

    // polygon tracking
    pwn_pkg::coord_t first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic            mid_reg;
    pwn_pkg::coord_t first_x_eff, first_y_eff;

    // difference stage
    logic            s1_valid_reg, s1_last_reg, s1_cross0_reg, s1_cross1_reg;
    pwn_pkg::diff_t  s1_dpx_reg, s1_dpy_reg, s1_dvx_reg, s1_dvy_reg;
    pwn_pkg::diff_t  s1_dfx_reg, s1_dfy_reg;
    logic            below_prev, below_vert, below_first;
    logic            s1_cross0_next, s1_cross1_next;

    // product stage
    logic            s2_valid_reg, s2_last_reg, s2_cross0_reg, s2_cross1_reg;
    pwn_pkg::prod_t  s2_p0a_reg, s2_p0b_reg, s2_p1a_reg, s2_p1b_reg;

    // sum and result
    pwn_pkg::sum_t   sum_reg, sum_next, sum_mid;
    logic            out_valid_reg;
    pwn_pkg::wind_t  out_wind_reg;
    logic            up0, dn0, up1, dn1;

    logic            s_beat, adv1, adv2, free1, free2, out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign adv2     = s2_valid_reg && (!s2_last_reg || out_free);
    assign free2    = !s2_valid_reg || adv2;
    assign adv1     = s1_valid_reg && free2;
    assign free1    = !s1_valid_reg || adv1;
    assign s_ready  = free1;
    assign s_beat   = s_valid && free1;

    assign m_valid   = out_valid_reg;
    assign m_winding = out_wind_reg;

    always_comb begin
        first_x_eff    = mid_reg ? first_x_reg : s_vertex_x;
        first_y_eff    = mid_reg ? first_y_reg : s_vertex_y;
        below_prev     = prev_y_reg < s_query_y;
        below_vert     = s_vertex_y < s_query_y;
        below_first    = first_y_eff < s_query_y;
        s1_cross0_next = mid_reg && (below_prev != below_vert);
        s1_cross1_next = s_last_vertex && (below_vert != below_first);
    end

    always_comb begin
        up0      = s2_cross0_reg && (s2_p0a_reg > s2_p0b_reg);
        dn0      = s2_cross0_reg && (s2_p0a_reg < s2_p0b_reg);
        up1      = s2_cross1_reg && (s2_p1a_reg > s2_p1b_reg);
        dn1      = s2_cross1_reg && (s2_p1a_reg < s2_p1b_reg);
        sum_mid  = pwn_pkg::sat_step(sum_reg, up0, dn0);
        sum_next = pwn_pkg::sat_step(sum_mid, up1, dn1);
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg       <= 1'b0;
            first_x_reg   <= '0;
            first_y_reg   <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
        end else begin
            if (s_beat) begin
                mid_reg     <= !s_last_vertex;
                first_x_reg <= first_x_eff;
                first_y_reg <= first_y_eff;
                prev_x_reg  <= s_vertex_x;
                prev_y_reg  <= s_vertex_y;
            end
            if (free1) begin
                s1_valid_reg <= s_valid;
            end
            if (free2) begin
                s2_valid_reg <= adv1;
            end
            if (adv2) begin
                sum_reg <= s2_last_reg ? '0 : sum_next;
            end
            if (out_free) begin
                out_valid_reg <= adv2 && s2_last_reg;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            s1_last_reg   <= s_last_vertex;
            s1_cross0_reg <= s1_cross0_next;
            s1_cross1_reg <= s1_cross1_next;
            s1_dpx_reg    <= pwn_pkg::coord_diff(prev_x_reg, s_query_x);
            s1_dpy_reg    <= pwn_pkg::coord_diff(prev_y_reg, s_query_y);
            s1_dvx_reg    <= pwn_pkg::coord_diff(s_vertex_x, s_query_x);
            s1_dvy_reg    <= pwn_pkg::coord_diff(s_vertex_y, s_query_y);
            s1_dfx_reg    <= pwn_pkg::coord_diff(first_x_eff, s_query_x);
            s1_dfy_reg    <= pwn_pkg::coord_diff(first_y_eff, s_query_y);
        end
        if (adv1) begin
            s2_last_reg   <= s1_last_reg;
            s2_cross0_reg <= s1_cross0_reg;
            s2_cross1_reg <= s1_cross1_reg;
            s2_p0a_reg    <= pwn_pkg::prod_t'(s1_dpx_reg) * pwn_pkg::prod_t'(s1_dvy_reg);
            s2_p0b_reg    <= pwn_pkg::prod_t'(s1_dpy_reg) * pwn_pkg::prod_t'(s1_dvx_reg);
            s2_p1a_reg    <= pwn_pkg::prod_t'(s1_dvx_reg) * pwn_pkg::prod_t'(s1_dfy_reg);
            s2_p1b_reg    <= pwn_pkg::prod_t'(s1_dvy_reg) * pwn_pkg::prod_t'(s1_dfx_reg);
        end
        if (adv2 && s2_last_reg && out_free) begin
            out_wind_reg <= pwn_pkg::half_sum(sum_next);
        end
    end

    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (sum_reg <= pwn_pkg::SUM_MAX) && (sum_reg >= pwn_pkg::SUM_MIN))
        else $error("crossing sum out of bound");

    a_wind_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_wind_reg <= pwn_pkg::WIND_MAX)
                          && (out_wind_reg >= pwn_pkg::WIND_MIN))
        else $error("winding out of range");

    a_out_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && m_ready && !(s2_valid_reg && s2_last_reg)) |=> !out_valid_reg)
        else $error("result beat repeated");

    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !free2) |=> s1_valid_reg)
        else $error("difference stage lost a vertex");

    a_sum_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv2 && s2_last_reg) |=> (sum_reg == '0))
        else $error("sum not cleared after last vertex");

endmodule
